### design/bsk_pkg.sv
// ----------------------------------------------------------------------------
// bsk_pkg
// Shared constants, codes and controller/datapath interface types for the
// best unique solution keeper.
// ----------------------------------------------------------------------------
`default_nettype none

package bsk_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int SCORE_BITS  = 32;
    localparam int KEY_BITS    = 64;
    localparam int SEEN_BITS   = 32;
    localparam int IDX_W       = 4;
    localparam int TOTAL_W     = 5;
    localparam int ENTRY_W     = KEY_BITS + SCORE_BITS + SEEN_BITS;

    typedef logic [2:0] act_t;
    typedef logic [1:0] req_t;

    localparam act_t ACT_DUP     = 3'd0;
    localparam act_t ACT_APPEND  = 3'd1;
    localparam act_t ACT_REPLACE = 3'd2;
    localparam act_t ACT_REJECT  = 3'd3;
    localparam act_t ACT_READ    = 3'd4;
    localparam act_t ACT_CLEAR   = 3'd5;

    localparam req_t REQ_OFFER = 2'd0;
    localparam req_t REQ_READ  = 2'd1;
    localparam req_t REQ_CLEAR = 2'd2;

    typedef struct packed {
        logic load;
        logic scan_start;
        logic scan;
        logic shift_start;
        logic shift;
        logic rd_sel;
        logic res_load;
        act_t act;
    } cmd_t;

    typedef struct packed {
        logic drained;
        logic ev_match;
        logic matched;
        logic fits;
        logic better;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

### design/best_unique_solution_keeper_core.sv
// ----------------------------------------------------------------------------
// best_unique_solution_keeper_core
// Ordered list of up to 16 distinct keys with scores and times-seen counts.
//
// Requests enter on in_valid/in_ready (offer, read, clear); one result per
// request leaves on res_valid/res_ready. The capacity register is written on
// cfg_valid/cfg_ready, which is always ready; write it only while idle.
// An offer scans the list one entry per cycle on the RAM read port, stopping
// early on a match; a replace then closes the gap behind the replaced entry.
// One request is in flight at a time; the next transfer is taken in the cycle
// after the result loads, even while the previous result waits in the output
// register. When the receiver stalls, the finished request holds in its last
// phase until the output register frees.
// Reset empties the list and sets capacity to 16; stored entries are not
// cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module best_unique_solution_keeper_core (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [bsk_pkg::TOTAL_W-1:0]           cfg_data,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire bsk_pkg::req_t                         req_type,
    input  wire logic [bsk_pkg::KEY_BITS-1:0]          solution_key,
    input  wire logic signed [bsk_pkg::SCORE_BITS-1:0] score,
    input  wire logic [bsk_pkg::IDX_W-1:0]             read_index,
    output logic                                       res_valid,
    input  wire logic                                  res_ready,
    output bsk_pkg::act_t                              action,
    output logic [bsk_pkg::IDX_W-1:0]                  position,
    output logic [bsk_pkg::TOTAL_W-1:0]                stored_count,
    output logic [bsk_pkg::KEY_BITS-1:0]               out_key,
    output logic signed [bsk_pkg::SCORE_BITS-1:0]      out_score,
    output logic [bsk_pkg::SEEN_BITS-1:0]              out_times_seen,
    output logic                                       out_valid
);
    import bsk_pkg::*;

    cmd_t    cmd;
    status_t st;

    assign cfg_ready = 1'b1;

    bsk_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .req_type (req_type),
        .st       (st),
        .cmd      (cmd)
    );

    bsk_dpath u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr         (cfg_valid && cfg_ready),
        .cfg_data       (cfg_data),
        .solution_key   (solution_key),
        .score          (score),
        .read_index     (read_index),
        .cmd            (cmd),
        .st             (st),
        .res_valid      (res_valid),
        .res_ready      (res_ready),
        .action         (action),
        .position       (position),
        .stored_count   (stored_count),
        .out_key        (out_key),
        .out_score      (out_score),
        .out_times_seen (out_times_seen),
        .out_valid      (out_valid)
    );

endmodule

`default_nettype wire

### design/bsk_ram.sv
// ----------------------------------------------------------------------------
// bsk_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bsk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

### design/bsk_ctrl.sv
// ----------------------------------------------------------------------------
// bsk_ctrl
// Request sequencer: scan, decide, shift, read and result phases of each request.
// ----------------------------------------------------------------------------
`default_nettype none

module bsk_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire bsk_pkg::req_t    req_type,
    input  wire bsk_pkg::status_t st,
    output bsk_pkg::cmd_t         cmd
);
    import bsk_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_SHIFT  = 3'd3;
    localparam logic [2:0] S_RD     = 3'd4;
    localparam logic [2:0] S_FIN    = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    act_t       act_reg;
    act_t       act_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        cmd.act    = act_reg;
        state_next = state_reg;
        act_next   = act_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    case (req_type)
                        REQ_OFFER:
                        begin
                            cmd.scan_start = 1'b1;
                            state_next     = S_SCAN;
                        end
                        REQ_READ:
                        begin
                            act_next   = ACT_READ;
                            state_next = S_RD;
                        end
                        REQ_CLEAR:
                        begin
                            act_next   = ACT_CLEAR;
                            state_next = S_FIN;
                        end
                        default:
                        begin
                            act_next   = ACT_REJECT;
                            state_next = S_FIN;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (st.ev_match || st.drained)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                state_next = S_FIN;
                if (st.matched)
                begin
                    act_next = ACT_DUP;
                end
                else if (st.fits)
                begin
                    act_next = ACT_APPEND;
                end
                else if (st.better)
                begin
                    cmd.shift_start = 1'b1;
                    act_next        = ACT_REPLACE;
                    state_next      = S_SHIFT;
                end
                else
                begin
                    act_next = ACT_REJECT;
                end
            end
            S_SHIFT:
            begin
                cmd.shift = 1'b1;
                if (st.drained)
                begin
                    state_next = S_FIN;
                end
            end
            S_RD:
            begin
                cmd.rd_sel = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.rd_sel = 1'b1;
                if (st.out_free)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            act_reg   <= ACT_REJECT;
        end
        else
        begin
            state_reg <= state_next;
            act_reg   <= act_next;
        end
    end

endmodule

`default_nettype wire

### design/bsk_dpath.sv
// ----------------------------------------------------------------------------
// bsk_dpath
// Entry store, scan pipeline, worst-entry tracker, gap close and result
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module bsk_dpath (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_wr,
    input  wire logic [bsk_pkg::TOTAL_W-1:0]          cfg_data,
    input  wire logic [bsk_pkg::KEY_BITS-1:0]         solution_key,
    input  wire logic signed [bsk_pkg::SCORE_BITS-1:0] score,
    input  wire logic [bsk_pkg::IDX_W-1:0]            read_index,
    input  wire bsk_pkg::cmd_t                        cmd,
    output bsk_pkg::status_t                          st,
    output logic                                      res_valid,
    input  wire logic                                 res_ready,
    output bsk_pkg::act_t                             action,
    output logic [bsk_pkg::IDX_W-1:0]                 position,
    output logic [bsk_pkg::TOTAL_W-1:0]               stored_count,
    output logic [bsk_pkg::KEY_BITS-1:0]              out_key,
    output logic signed [bsk_pkg::SCORE_BITS-1:0]     out_score,
    output logic [bsk_pkg::SEEN_BITS-1:0]             out_times_seen,
    output logic                                      out_valid
);
    import bsk_pkg::*;

    localparam logic [TOTAL_W-1:0] MAX_TOTAL = TOTAL_W'(MAX_ENTRIES);

    logic [KEY_BITS-1:0]          key_reg;
    logic signed [SCORE_BITS-1:0] score_reg;
    logic [IDX_W-1:0]             ridx_reg;
    logic [TOTAL_W-1:0]           capacity_reg;
    logic [TOTAL_W-1:0]           total_reg;
    logic [TOTAL_W-1:0]           total_next;
    logic [TOTAL_W-1:0]           idx_reg;
    logic                         ev_vld_reg;
    logic [IDX_W-1:0]             ev_idx_reg;
    logic                         have_max_reg;
    logic signed [SCORE_BITS-1:0] max_score_reg;
    logic [IDX_W-1:0]             max_idx_reg;
    logic                         matched_reg;
    logic [IDX_W-1:0]             match_idx_reg;
    logic signed [SCORE_BITS-1:0] match_score_reg;
    logic [SEEN_BITS-1:0]         match_seen_reg;

    logic                         res_valid_reg;
    act_t                         action_reg;
    logic [IDX_W-1:0]             position_reg;
    logic [TOTAL_W-1:0]           count_reg;
    logic [KEY_BITS-1:0]          out_key_reg;
    logic signed [SCORE_BITS-1:0] out_score_reg;
    logic [SEEN_BITS-1:0]         out_seen_reg;
    logic                         out_valid_reg;

    logic [IDX_W-1:0]             position_next;
    logic [KEY_BITS-1:0]          out_key_next;
    logic signed [SCORE_BITS-1:0] out_score_next;
    logic [SEEN_BITS-1:0]         out_seen_next;
    logic                         out_valid_next;

    logic                         wr_en;
    logic [IDX_W-1:0]             wr_addr;
    logic [ENTRY_W-1:0]           wr_data;
    logic [IDX_W-1:0]             rd_addr;
    logic [ENTRY_W-1:0]           rd_data;
    logic [KEY_BITS-1:0]          rd_key;
    logic signed [SCORE_BITS-1:0] rd_score;
    logic [SEEN_BITS-1:0]         rd_seen;

    logic                         issue;
    logic                         eval;
    logic                         key_hit;
    logic [TOTAL_W-1:0]           eff_cap;
    logic                         rd_in_range;

    bsk_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_key   = rd_data[ENTRY_W-1 -: KEY_BITS];
    assign rd_score = rd_data[SCORE_BITS+SEEN_BITS-1 -: SCORE_BITS];
    assign rd_seen  = rd_data[SEEN_BITS-1:0];

    assign rd_addr = cmd.rd_sel ? ridx_reg : idx_reg[IDX_W-1:0];
    assign issue   = (cmd.scan || cmd.shift) && (idx_reg < total_reg);
    assign eval    = cmd.scan && ev_vld_reg;
    assign key_hit = (rd_key == key_reg);

    always_comb
    begin
        if (capacity_reg == '0)
        begin
            eff_cap = TOTAL_W'(1);
        end
        else if (capacity_reg > MAX_TOTAL)
        begin
            eff_cap = MAX_TOTAL;
        end
        else
        begin
            eff_cap = capacity_reg;
        end
    end

    assign rd_in_range = ({1'b0, ridx_reg} < total_reg);

    assign st.drained  = (idx_reg >= total_reg) && !ev_vld_reg;
    assign st.ev_match = eval && key_hit;
    assign st.matched  = matched_reg;
    assign st.fits     = (total_reg < eff_cap);
    assign st.better   = have_max_reg && (score_reg < max_score_reg);
    assign st.out_free = !res_valid_reg || res_ready;

    // entry writes: gap close, count bump, new key
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = ev_idx_reg - IDX_W'(1);
        wr_data = rd_data;
        if (cmd.shift && ev_vld_reg)
        begin
            wr_en = 1'b1;
        end
        if (cmd.res_load)
        begin
            case (cmd.act)
                ACT_DUP:
                begin
                    wr_en   = 1'b1;
                    wr_addr = match_idx_reg;
                    wr_data = {key_reg, match_score_reg, match_seen_reg};
                end
                ACT_APPEND:
                begin
                    wr_en   = 1'b1;
                    wr_addr = total_reg[IDX_W-1:0];
                    wr_data = {key_reg, score_reg, SEEN_BITS'(1)};
                end
                ACT_REPLACE:
                begin
                    wr_en   = 1'b1;
                    wr_addr = total_reg[IDX_W-1:0] - IDX_W'(1);
                    wr_data = {key_reg, score_reg, SEEN_BITS'(1)};
                end
                default:
                begin
                    wr_en = wr_en;
                end
            endcase
        end
    end

    always_comb
    begin
        total_next     = total_reg;
        position_next  = '0;
        out_key_next   = '0;
        out_score_next = '0;
        out_seen_next  = '0;
        out_valid_next = 1'b0;
        case (cmd.act)
            ACT_DUP:
            begin
                position_next = match_idx_reg;
            end
            ACT_APPEND:
            begin
                total_next    = total_reg + TOTAL_W'(1);
                position_next = total_reg[IDX_W-1:0];
            end
            ACT_REPLACE:
            begin
                position_next = total_reg[IDX_W-1:0] - IDX_W'(1);
            end
            ACT_READ:
            begin
                position_next = ridx_reg;
                if (rd_in_range)
                begin
                    out_key_next   = rd_key;
                    out_score_next = rd_score;
                    out_seen_next  = rd_seen;
                    out_valid_next = 1'b1;
                end
            end
            ACT_CLEAR:
            begin
                total_next = '0;
            end
            default:
            begin
                position_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg   <= solution_key;
            score_reg <= score;
            ridx_reg  <= read_index;
        end
        if (issue)
        begin
            ev_idx_reg <= idx_reg[IDX_W-1:0];
        end
        if (eval)
        begin
            if (key_hit)
            begin
                match_idx_reg   <= ev_idx_reg;
                match_score_reg <= rd_score;
                match_seen_reg  <= (rd_seen == '1) ? rd_seen : rd_seen + SEEN_BITS'(1);
            end
            else if (!have_max_reg || (rd_score > max_score_reg))
            begin
                max_score_reg <= rd_score;
                max_idx_reg   <= ev_idx_reg;
            end
        end
        if (cmd.res_load)
        begin
            action_reg    <= cmd.act;
            position_reg  <= position_next;
            count_reg     <= total_next;
            out_key_reg   <= out_key_next;
            out_score_reg <= out_score_next;
            out_seen_reg  <= out_seen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg  <= MAX_TOTAL;
            total_reg     <= '0;
            idx_reg       <= '0;
            ev_vld_reg    <= 1'b0;
            have_max_reg  <= 1'b0;
            matched_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                capacity_reg <= cfg_data;
            end
            if (cmd.res_load)
            begin
                total_reg <= total_next;
            end
            if (cmd.scan_start)
            begin
                idx_reg <= '0;
            end
            else if (cmd.shift_start)
            begin
                idx_reg <= {1'b0, max_idx_reg} + TOTAL_W'(1);
            end
            else if (issue)
            begin
                idx_reg <= idx_reg + TOTAL_W'(1);
            end
            if (cmd.scan_start || cmd.shift_start)
            begin
                ev_vld_reg <= 1'b0;
            end
            else
            begin
                ev_vld_reg <= issue;
            end
            if (cmd.scan_start)
            begin
                have_max_reg <= 1'b0;
                matched_reg  <= 1'b0;
            end
            else if (eval)
            begin
                if (key_hit)
                begin
                    matched_reg <= 1'b1;
                end
                else
                begin
                    have_max_reg <= 1'b1;
                end
            end
            if (cmd.res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    assign res_valid      = res_valid_reg;
    assign action         = action_reg;
    assign position       = position_reg;
    assign stored_count   = count_reg;
    assign out_key        = out_key_reg;
    assign out_score      = out_score_reg;
    assign out_times_seen = out_seen_reg;
    assign out_valid      = out_valid_reg;

`ifndef SYNTHESIS
    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= MAX_TOTAL)
        else $error("entry total above store depth");

    a_wr_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && !(cmd.res_load && cmd.act == ACT_APPEND))
        |-> ({1'b0, wr_addr} < total_reg))
        else $error("entry write outside held list");

    a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.res_load && cmd.act == ACT_APPEND)
        |=> (total_reg == $past(total_reg) + TOTAL_W'(1)))
        else $error("append did not grow the list");

    a_read_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && out_valid_reg) |-> ({1'b0, position_reg} < count_reg))
        else $error("valid read beyond held list");
`endif

endmodule

`default_nettype wire
